// File: hw/rtl/hte_pkg.sv
// hte_pkg: shared types and constants of the huffman tree expander
// used by the controller, datapath and checker
`timescale 1ns / 1ps

package hte_pkg;

  // item kinds on the input channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;

  // tree geometry
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned BRANCH_W   = 9;
  localparam int unsigned ENTRY_W    = 2 * BRANCH_W;
  localparam int unsigned NODE_COUNT = 255;
  localparam logic [NODE_W-1:0] HEAD_NODE = 8'd254;
  localparam logic [NODE_W-1:0] NO_NODE   = 8'd255;

  // bit position within a compressed byte
  localparam int unsigned BIT_CNT_W = 3;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  // commands from controller to datapath
  typedef struct packed {
    logic load_node;
    logic set_length;
    logic start_byte;
    logic step;
    logic flush;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic leaf;
    logic last_bit;
    logic rem_one;
    logic rem_zero;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/hte_in_if.sv
// hte_in_if: input channel of the huffman tree expander
// depends on nothing but the payload widths listed here
`timescale 1ns / 1ps

interface hte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  node_index;
  logic [8:0]  branch_zero;
  logic [8:0]  branch_one;
  logic [23:0] chunk_length;
  logic [7:0]  compressed_byte;

  modport source (
    output valid, kind, node_index, branch_zero, branch_one, chunk_length,
      compressed_byte,
    input ready
  );
  modport sink (
    input valid, kind, node_index, branch_zero, branch_one, chunk_length,
      compressed_byte,
    output ready
  );
endinterface

// File: hw/rtl/hte_out_if.sv
// hte_out_if: result channel of the huffman tree expander
// depends on nothing but the payload widths listed here
`timescale 1ns / 1ps

interface hte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic       last;
  logic       chunk_done;

  modport source (
    output valid, decoded_byte, last, chunk_done,
    input ready
  );
  modport sink (
    input valid, decoded_byte, last, chunk_done,
    output ready
  );
endinterface

// File: hw/rtl/hte_ctrl.sv
// hte_ctrl: state machine that sequences load, begin and byte items
// depends on hte_pkg for the command and status structs and kind codes
`timescale 1ns / 1ps

module hte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_kind_i,
  output logic             in_ready_o,
  input  hte_pkg::status_t status_i,
  output hte_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;
  logic       stall;
  logic       walk_end;

  // a leaf with a full pending slot must wait for the output register
  assign stall    = status_i.leaf && status_i.pend_valid && !status_i.out_free;
  assign walk_end = status_i.last_bit || (status_i.leaf && status_i.rem_one);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_kind_i)
            hte_pkg::KIND_LOAD:  cmd_o.load_node  = 1'b1;
            hte_pkg::KIND_BEGIN: cmd_o.set_length = 1'b1;
            hte_pkg::KIND_BYTE: begin
              if (!status_i.rem_zero) begin
                cmd_o.start_byte = 1'b1;
                state_d          = StWalk;
              end
            end
            default: ;
          endcase
        end
      end
      StWalk: begin
        cmd_o.step = !stall;
        if (!stall && walk_end) begin
          state_d = (status_i.pend_valid || status_i.leaf) ? StFlush : StIdle;
        end
      end
      StFlush: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/hte_datapath.sv
// hte_datapath: node table, tree walk registers, length counter and result buffers
// depends on hte_pkg for widths, constants and the command and status structs
`timescale 1ns / 1ps

module hte_datapath #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hte_pkg::cmd_t    cmd_i,
  output hte_pkg::status_t status_o,
  input  logic [7:0]       node_index_i,
  input  logic [8:0]       branch_zero_i,
  input  logic [8:0]       branch_one_i,
  input  logic [23:0]      chunk_length_i,
  input  logic [7:0]       compressed_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       decoded_byte_o,
  output logic             last_o,
  output logic             chunk_done_o
);

  localparam int unsigned NW = hte_pkg::NODE_W;
  localparam int unsigned BW = hte_pkg::BRANCH_W;

  // node table, undefined until written
  logic [hte_pkg::ENTRY_W-1:0] mem_q [hte_pkg::NODE_COUNT];
  logic [hte_pkg::ENTRY_W-1:0] rd_data_q;
  logic                        no_node_q;

  logic [NW-1:0]          node_q, node_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_dec;
  logic [7:0]             byte_q;
  logic [hte_pkg::BIT_CNT_W-1:0] cnt_q;
  logic [BW-1:0]          value;
  logic                   leaf;
  logic [31:0]            length_ext;

  logic       pend_valid_q;
  logic [7:0] pend_byte_q;
  logic       pend_done_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_done_q;
  logic       out_free;
  logic       push;

  // branch selected by the current bit; the missing node reads as zero
  always_comb begin
    if (no_node_q) begin
      value = '0;
    end else if (byte_q[0]) begin
      value = rd_data_q[hte_pkg::ENTRY_W-1:BW];
    end else begin
      value = rd_data_q[BW-1:0];
    end
  end
  assign leaf = !value[BW-1];

  assign rem_dec    = rem_q - LENGTH_BITS'(1);
  assign length_ext = {8'd0, chunk_length_i};
  assign out_free   = !out_valid_q || out_ready_i;
  assign push       = cmd_i.step && leaf;

  // next node of the walk, also the table read address
  always_comb begin
    node_d = node_q;
    if (cmd_i.set_length) begin
      node_d = hte_pkg::HEAD_NODE;
    end else if (cmd_i.step) begin
      node_d = leaf ? hte_pkg::HEAD_NODE : value[NW-1:0];
    end
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_node && (node_index_i != hte_pkg::NO_NODE)) begin
      mem_q[node_index_i] <= {branch_one_i, branch_zero_i};
    end
    rd_data_q <= mem_q[node_d];
  end

  // walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q    <= hte_pkg::HEAD_NODE;
      no_node_q <= 1'b0;
      rem_q     <= '0;
      cnt_q     <= '0;
    end else begin
      node_q    <= node_d;
      no_node_q <= (node_d == hte_pkg::NO_NODE);
      if (cmd_i.set_length) begin
        rem_q <= length_ext[LENGTH_BITS-1:0];
      end else if (push) begin
        rem_q <= rem_dec;
      end
      if (cmd_i.start_byte) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // compressed byte shifts out least significant bit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_byte) begin
      byte_q <= compressed_byte_i;
    end else if (cmd_i.step) begin
      byte_q <= {1'b0, byte_q[7:1]};
    end
  end

  // pending result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (push) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  // pending result payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_byte_q <= value[7:0];
      pend_done_q <= (rem_dec == '0);
    end
  end

  // output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((push && pend_valid_q) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload, last only when the item's walk has ended
  always_ff @(posedge clk_i) begin
    if ((push && pend_valid_q) || cmd_i.flush) begin
      out_byte_q <= pend_byte_q;
      out_done_q <= pend_done_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_byte_o = out_byte_q;
  assign last_o         = out_last_q;
  assign chunk_done_o   = out_done_q;

  assign status_o.leaf       = leaf;
  assign status_o.last_bit   = (cnt_q == hte_pkg::LAST_BIT);
  assign status_o.rem_one    = (rem_q == LENGTH_BITS'(1));
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

endmodule

// File: hw/rtl/huffman_tree_expander_core.sv
// huffman_tree_expander_core: top level of the huffman tree expander
// depends on hte_pkg, hte_in_if, hte_out_if, hte_ctrl and hte_datapath
//
// Usage: items arrive on in_i (valid/ready). A load item (kind 0) writes
// both branches of one tree node, a begin item (kind 1) sets the number of
// decoded bytes of the chunk and returns the walk to the head node, and a
// compressed byte item (kind 2) walks the tree one bit per cycle, lsb first,
// unless the walk holds for full result buffers. Decoded bytes leave on
// out_o (valid/ready); last marks the final result of an input item and
// chunk_done the result that completes the chunk. Load and begin items do
// not block the next item. A byte item is accepted, walked over up to eight
// bits (one dependent node table read each, which sets the rate) and then
// releases its final result, if one is held. Results pass through a pending
// slot and an output register, so the walk runs on while one result waits;
// with both full, the walk holds until the receiver takes one. Input ready
// is low while a byte is being walked. Reset clears the length to zero, the
// walk to the head node and empties the result buffers; the node table keeps
// no reset value and must be loaded before use.
`timescale 1ns / 1ps

module huffman_tree_expander_core #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  hte_in_if.sink    in_i,
  hte_out_if.source out_o
);

  hte_pkg::cmd_t    cmd;
  hte_pkg::status_t status;

  // sequencing
  hte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, walk and result buffers
  hte_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .node_index_i      (in_i.node_index),
    .branch_zero_i     (in_i.branch_zero),
    .branch_one_i      (in_i.branch_one),
    .chunk_length_i    (in_i.chunk_length),
    .compressed_byte_i (in_i.compressed_byte),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .decoded_byte_o    (out_o.decoded_byte),
    .last_o            (out_o.last),
    .chunk_done_o      (out_o.chunk_done)
  );

endmodule

// File: hw/rtl/hte_checker.sv
// hte_checker: port level assertions for the huffman tree expander
// depends on hte_pkg kind codes; bound to huffman_tree_expander_core below
`timescale 1ns / 1ps

module hte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_kind_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_done_i
);

  // a stalled result item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // a stalled result item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i)
      && $stable(out_done_i))
    else $error("result payload changed while stalled");

  // the item that completes a chunk is always the final one of its input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_last_i)
    else $error("chunk completed without last");

  // load and begin items never block the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
      (in_kind_i == hte_pkg::KIND_LOAD || in_kind_i == hte_pkg::KIND_BEGIN)
    |=> in_ready_i)
    else $error("ready dropped after load or begin item");

endmodule

bind huffman_tree_expander_core hte_checker u_hte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.decoded_byte),
  .out_last_i  (out_o.last),
  .out_done_i  (out_o.chunk_done)
);
